>>> hw/rtl/hgvn_pkg.sv
package hgvn_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int ZW   = 24;
  localparam int MW   = 30;
  localparam int SQW  = 64;
  localparam int NW   = 26;
  localparam int QW   = 17;
  localparam int RW   = 33;
  localparam int ACW  = 20;

  localparam logic [ZW-1:0] UNIT_Z = 24'd65536;

  localparam logic OPER_WRITE = 1'b0;
  localparam logic OPER_READ  = 1'b1;

  localparam logic [1:0] REG_GRID_WIDTH   = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_HEIGHT_SCALE = 2'd2;

  localparam logic [5:0] POS_STEPS    = 6'd26;
  localparam logic [5:0] FETCH_STEPS  = 6'd10;
  localparam logic [5:0] SQUARE_STEPS = 6'd3;
  localparam logic [5:0] SQRT_STEPS   = 6'd32;
  localparam logic [5:0] DIV_STEPS    = 6'd17;
  localparam logic [2:0] TRI_LAST     = 3'd5;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WRITE,
    OP_START,
    OP_POS_INIT,
    OP_POS_STEP,
    OP_FETCH,
    OP_SETUP,
    OP_NORM,
    OP_SQUARE,
    OP_SQRT,
    OP_DIV,
    OP_ACC,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [5:0] idx;
  } cmd_t;

  typedef struct packed {
    logic read_ok;
    logic tri_valid;
  } status_t;

  typedef struct packed {
    logic       up;
    logic       left;
    logic [3:0] ka;
    logic [3:0] kb;
    logic [3:0] kc;
    logic [3:0] kd;
  } tri_sel_t;

  // neighbor k of the 3x3 window: {row offset, column offset}, both shifted by one
  function automatic logic [3:0] nb_offset(input logic [3:0] k);
    logic [3:0] res;
    unique case (k)
      4'd0: res = {2'd0, 2'd0};
      4'd1: res = {2'd0, 2'd1};
      4'd2: res = {2'd0, 2'd2};
      4'd3: res = {2'd1, 2'd0};
      4'd4: res = {2'd1, 2'd1};
      4'd5: res = {2'd1, 2'd2};
      4'd6: res = {2'd2, 2'd0};
      4'd7: res = {2'd2, 2'd1};
      4'd8: res = {2'd2, 2'd2};
      default: res = 4'd0;
    endcase
    return res;
  endfunction

  // v0 = w*(z[ka]-z[kb]), v1 = h*(z[kc]-z[kd])
  function automatic tri_sel_t tri_sel(input logic [2:0] t);
    tri_sel_t s;
    unique case (t)
      3'd0: s = '{up: 1'b0, left: 1'b0, ka: 4'd4, kb: 4'd5, kc: 4'd5, kd: 4'd8};
      3'd1: s = '{up: 1'b0, left: 1'b0, ka: 4'd7, kb: 4'd8, kc: 4'd4, kd: 4'd7};
      3'd2: s = '{up: 1'b0, left: 1'b1, ka: 4'd3, kb: 4'd4, kc: 4'd4, kd: 4'd7};
      3'd3: s = '{up: 1'b1, left: 1'b1, ka: 4'd0, kb: 4'd1, kc: 4'd1, kd: 4'd4};
      3'd4: s = '{up: 1'b1, left: 1'b1, ka: 4'd3, kb: 4'd4, kc: 4'd0, kd: 4'd3};
      3'd5: s = '{up: 1'b1, left: 1'b0, ka: 4'd4, kb: 4'd5, kc: 4'd1, kd: 4'd4};
      default: s = '{up: 1'b0, left: 1'b0, ka: 4'd4, kb: 4'd4, kc: 4'd4, kd: 4'd4};
    endcase
    return s;
  endfunction

endpackage

>>> hw/rtl/hgvn_ctrl.sv
module hgvn_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_oper_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  hgvn_pkg::status_t status_i,
  output hgvn_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_POS,
    ST_FETCH,
    ST_SETUP,
    ST_NORM,
    ST_SQUARE,
    ST_SQRT,
    ST_DIV,
    ST_ACC,
    ST_EMIT
  } state_e;

  state_e     state_q;
  logic [5:0] cnt_q;
  logic [2:0] tri_q;
  logic       out_valid_q;
  logic       emit_fire;

  assign out_valid_o = out_valid_q;
  assign emit_fire   = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = hgvn_pkg::OP_NONE;
    cmd_o.idx  = 6'd0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = (in_oper_i == hgvn_pkg::OPER_READ) ? hgvn_pkg::OP_START
                                                        : hgvn_pkg::OP_WRITE;
        end
      end
      ST_CHECK: begin
        if (status_i.read_ok) cmd_o.op = hgvn_pkg::OP_POS_INIT;
      end
      ST_POS: cmd_o.op = hgvn_pkg::OP_POS_STEP;
      ST_FETCH: begin
        cmd_o.op  = hgvn_pkg::OP_FETCH;
        cmd_o.idx = cnt_q;
      end
      ST_SETUP: begin
        cmd_o.op  = hgvn_pkg::OP_SETUP;
        cmd_o.idx = {3'd0, tri_q};
      end
      ST_NORM: cmd_o.op = hgvn_pkg::OP_NORM;
      ST_SQUARE: begin
        cmd_o.op  = hgvn_pkg::OP_SQUARE;
        cmd_o.idx = cnt_q;
      end
      ST_SQRT: cmd_o.op = hgvn_pkg::OP_SQRT;
      ST_DIV: begin
        cmd_o.op  = hgvn_pkg::OP_DIV;
        cmd_o.idx = cnt_q;
      end
      ST_ACC: cmd_o.op = hgvn_pkg::OP_ACC;
      ST_EMIT: begin
        if (emit_fire) cmd_o.op = hgvn_pkg::OP_EMIT;
      end
      default: cmd_o.op = hgvn_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 6'd0;
      tri_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= 6'd0;
          tri_q <= 3'd0;
          if (in_valid_i && in_oper_i == hgvn_pkg::OPER_READ) state_q <= ST_CHECK;
        end
        ST_CHECK: state_q <= status_i.read_ok ? ST_POS : ST_IDLE;
        ST_POS: begin
          if (cnt_q == hgvn_pkg::POS_STEPS - 6'd1) begin
            cnt_q   <= 6'd0;
            state_q <= ST_FETCH;
          end else cnt_q <= cnt_q + 6'd1;
        end
        ST_FETCH: begin
          if (cnt_q == hgvn_pkg::FETCH_STEPS - 6'd1) begin
            cnt_q   <= 6'd0;
            state_q <= ST_SETUP;
          end else cnt_q <= cnt_q + 6'd1;
        end
        ST_SETUP: begin
          if (status_i.tri_valid) state_q <= ST_NORM;
          else if (tri_q == hgvn_pkg::TRI_LAST) state_q <= ST_EMIT;
          else tri_q <= tri_q + 3'd1;
        end
        ST_NORM: state_q <= ST_SQUARE;
        ST_SQUARE: begin
          if (cnt_q == hgvn_pkg::SQUARE_STEPS - 6'd1) begin
            cnt_q   <= 6'd0;
            state_q <= ST_SQRT;
          end else cnt_q <= cnt_q + 6'd1;
        end
        ST_SQRT: begin
          if (cnt_q == hgvn_pkg::SQRT_STEPS - 6'd1) begin
            cnt_q   <= 6'd0;
            state_q <= ST_DIV;
          end else cnt_q <= cnt_q + 6'd1;
        end
        ST_DIV: begin
          if (cnt_q == hgvn_pkg::DIV_STEPS - 6'd1) begin
            cnt_q   <= 6'd0;
            state_q <= ST_ACC;
          end else cnt_q <= cnt_q + 6'd1;
        end
        ST_ACC: begin
          if (tri_q == hgvn_pkg::TRI_LAST) state_q <= ST_EMIT;
          else begin
            tri_q   <= tri_q + 3'd1;
            state_q <= ST_SETUP;
          end
        end
        ST_EMIT: begin
          if (emit_fire) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == hgvn_pkg::OP_EMIT) |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending one");

  a_read_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_oper_i == hgvn_pkg::OPER_READ) |=>
    (state_q == ST_CHECK))
    else $error("accepted read did not start");

  a_div_after_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == 6'd0) |-> ($past(state_q) == ST_SQRT))
    else $error("division started without a root");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (cmd_o.op != hgvn_pkg::OP_WRITE && !in_ready_o))
    else $error("transaction taken while busy");

endmodule

>>> hw/rtl/hgvn_dp.sv
module hgvn_dp #(
  parameter int MAX_WIDTH  = hgvn_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = hgvn_pkg::DEF_MAX_HEIGHT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hgvn_pkg::cmd_t         cmd_i,
  output hgvn_pkg::status_t      status_o,
  input  logic [8:0]             row_i,
  input  logic [8:0]             column_i,
  input  logic [7:0]             height_sample_i,
  input  logic [8:0]             grid_width_i,
  input  logic [8:0]             grid_height_i,
  input  logic [15:0]            height_scale_i,
  output logic [16:0]            pos_x_o,
  output logic [16:0]            pos_y_o,
  output logic [23:0]            pos_z_o,
  output logic signed [19:0]     normal_x_o,
  output logic signed [19:0]     normal_y_o,
  output logic signed [19:0]     normal_z_o
);

  localparam int EW    = $clog2(MAX_WIDTH + 1);
  localparam int EH    = $clog2(MAX_HEIGHT + 1);
  localparam int EMAX  = (EW > EH) ? EW : EH;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = ((EMAX > 9) ? EMAX : 9) + 1;
  localparam int ZW    = hgvn_pkg::ZW;
  localparam int DW    = ZW + 1;
  localparam int VW    = DW + EMAX + 1;
  localparam int MW    = hgvn_pkg::MW;
  localparam int PW    = 2 * MW;
  localparam int SQW   = hgvn_pkg::SQW;
  localparam int NW    = hgvn_pkg::NW;
  localparam int QW    = hgvn_pkg::QW;
  localparam int RW    = hgvn_pkg::RW;
  localparam int ACW   = hgvn_pkg::ACW;
  localparam int SHW   = $clog2(VW);

  logic [7:0]            mem [DEPTH];
  logic [7:0]            mem_rd_q;
  logic                  rd_vld_q;
  logic [8:0]            row_q, col_q;
  logic [EW-1:0]         effw_q;
  logic [EH-1:0]         effh_q;
  logic [ZW-1:0]         z_q [9];
  logic [EW-1:0]         posx_rem_q;
  logic [EH-1:0]         posy_rem_q;
  logic [NW-1:0]         posx_num_q, posy_num_q;
  logic signed [VW-1:0]  v0_q, v1_q;
  logic [MW-1:0]         mag_q [3];
  logic                  sgn_q [3];
  logic [SQW-1:0]        sum_q, sq_res_q, sq_bit_q;
  logic [RW-1:0]         drem_q [3];
  logic [QW-1:0]         dq_q [3];
  logic signed [ACW-1:0] acc_q [3];

  logic                  wr_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [3:0]            nb;
  logic [CW-1:0]         nb_r, nb_c, effw_c, effh_c;
  logic                  nb_in;
  logic [ZW-1:0]         zprod;
  logic [EW-1:0]         effw_d;
  logic [EH-1:0]         effh_d;
  hgvn_pkg::tri_sel_t    sel;
  logic [CW-1:0]         q_r, q_c;
  logic signed [VW-1:0]  p0, p1;
  logic [VW-1:0]         mag_full [3];
  logic [VW-1:0]         mag_or;
  logic [SHW-1:0]        sh;
  logic [PW-1:0]         sq;
  logic [SQW-1:0]        sq_try;
  logic [31:0]           root;
  logic [RW-1:0]         dbase [3];
  logic                  dge [3];
  logic [EW:0]           px_sh;
  logic [EH:0]           py_sh;
  logic                  px_ge, py_ge;

  assign effw_c = CW'(effw_q);
  assign effh_c = CW'(effh_q);

  assign status_o.read_ok = (CW'(row_q) <= effh_c) && (CW'(col_q) <= effw_c);

  assign wr_en   = (cmd_i.op == hgvn_pkg::OP_WRITE) && (32'(row_i) < MAX_HEIGHT) &&
                   (32'(column_i) < MAX_WIDTH);
  assign wr_addr = AW'(row_i) * AW'(MAX_WIDTH) + AW'(column_i);

  assign nb      = hgvn_pkg::nb_offset(cmd_i.idx[3:0]);
  assign nb_r    = CW'(row_q) + CW'(nb[3:2]);
  assign nb_c    = CW'(col_q) + CW'(nb[1:0]);
  assign nb_in   = (nb_r >= CW'(2)) && (nb_r <= effh_c) && (nb_c >= CW'(2)) &&
                   (nb_c <= effw_c);
  assign rd_addr = AW'(nb_r - CW'(1)) * AW'(MAX_WIDTH) + AW'(nb_c - CW'(1));
  assign zprod   = ZW'(mem_rd_q) * ZW'(height_scale_i);

  always_comb begin
    if (grid_width_i == 9'd0) effw_d = EW'(1);
    else if (32'(grid_width_i) > MAX_WIDTH) effw_d = EW'(MAX_WIDTH);
    else effw_d = EW'(grid_width_i);
    if (grid_height_i == 9'd0) effh_d = EH'(1);
    else if (32'(grid_height_i) > MAX_HEIGHT) effh_d = EH'(MAX_HEIGHT);
    else effh_d = EH'(grid_height_i);
  end

  assign sel   = hgvn_pkg::tri_sel(cmd_i.idx[2:0]);
  assign q_r   = CW'(row_q) + CW'(!sel.up);
  assign q_c   = CW'(col_q) + CW'(!sel.left);
  assign status_o.tri_valid = (q_r >= CW'(1)) && (q_r <= effh_c) && (q_c >= CW'(1)) &&
                              (q_c <= effw_c);
  assign p0 = VW'($signed({1'b0, z_q[sel.ka]}) - $signed({1'b0, z_q[sel.kb]})) *
              VW'($signed({1'b0, effw_q}));
  assign p1 = VW'($signed({1'b0, z_q[sel.kc]}) - $signed({1'b0, z_q[sel.kd]})) *
              VW'($signed({1'b0, effh_q}));

  always_comb begin
    mag_full[0] = v0_q[VW-1] ? $unsigned(-v0_q) : $unsigned(v0_q);
    mag_full[1] = v1_q[VW-1] ? $unsigned(-v1_q) : $unsigned(v1_q);
    mag_full[2] = VW'(hgvn_pkg::UNIT_Z);
    mag_or      = mag_full[0] | mag_full[1] | mag_full[2];
    sh          = '0;
    for (int i = MW; i < VW; i++) begin
      if (mag_or[i]) sh = SHW'(i - MW + 1);
    end
  end

  assign sq     = PW'(mag_q[cmd_i.idx[1:0]]) * PW'(mag_q[cmd_i.idx[1:0]]);
  assign sq_try = sq_res_q + sq_bit_q;
  assign root   = sq_res_q[31:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dbase[k] = (cmd_i.idx == 6'd0) ? RW'(mag_q[k]) : {drem_q[k][RW-2:0], 1'b0};
      dge[k]   = dbase[k] >= RW'(root);
    end
  end

  assign px_sh = {posx_rem_q, posx_num_q[NW-1]};
  assign py_sh = {posy_rem_q, posy_num_q[NW-1]};
  assign px_ge = px_sh >= {1'b0, effw_q};
  assign py_ge = py_sh >= {1'b0, effh_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= height_sample_i;
    mem_rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      hgvn_pkg::OP_START: begin
        row_q  <= row_i;
        col_q  <= column_i;
        effw_q <= effw_d;
        effh_q <= effh_d;
        for (int k = 0; k < 3; k++) acc_q[k] <= '0;
      end
      hgvn_pkg::OP_POS_INIT: begin
        posx_rem_q <= '0;
        posy_rem_q <= '0;
        posx_num_q <= NW'({col_q, 16'h0000}) + NW'(effw_q >> 1);
        posy_num_q <= NW'({row_q, 16'h0000}) + NW'(effh_q >> 1);
      end
      hgvn_pkg::OP_POS_STEP: begin
        posx_rem_q <= px_ge ? EW'(px_sh - {1'b0, effw_q}) : EW'(px_sh);
        posy_rem_q <= py_ge ? EH'(py_sh - {1'b0, effh_q}) : EH'(py_sh);
        posx_num_q <= {posx_num_q[NW-2:0], px_ge};
        posy_num_q <= {posy_num_q[NW-2:0], py_ge};
      end
      hgvn_pkg::OP_FETCH: begin
        rd_vld_q <= nb_in;
        if (cmd_i.idx[3:0] != 4'd0) begin
          z_q[cmd_i.idx[3:0] - 4'd1] <= rd_vld_q ? zprod : '0;
        end
      end
      hgvn_pkg::OP_SETUP: begin
        v0_q <= p0;
        v1_q <= p1;
      end
      hgvn_pkg::OP_NORM: begin
        for (int k = 0; k < 3; k++) mag_q[k] <= MW'(mag_full[k] >> sh);
        sgn_q[0] <= v0_q[VW-1];
        sgn_q[1] <= v1_q[VW-1];
        sgn_q[2] <= 1'b0;
        sum_q    <= '0;
        sq_res_q <= '0;
        sq_bit_q <= SQW'(1) << 62;
      end
      hgvn_pkg::OP_SQUARE: sum_q <= sum_q + SQW'(sq);
      hgvn_pkg::OP_SQRT: begin
        if (sum_q >= sq_try) begin
          sum_q    <= sum_q - sq_try;
          sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
      end
      hgvn_pkg::OP_DIV: begin
        for (int k = 0; k < 3; k++) begin
          drem_q[k] <= dge[k] ? dbase[k] - RW'(root) : dbase[k];
          dq_q[k]   <= {dq_q[k][QW-2:0], dge[k]};
        end
      end
      hgvn_pkg::OP_ACC: begin
        if (root != 32'd0) begin
          for (int k = 0; k < 3; k++) begin
            acc_q[k] <= sgn_q[k] ? acc_q[k] - $signed(ACW'(dq_q[k]))
                                 : acc_q[k] + $signed(ACW'(dq_q[k]));
          end
        end
      end
      hgvn_pkg::OP_EMIT: begin
        pos_x_o    <= posx_num_q[16:0];
        pos_y_o    <= posy_num_q[16:0];
        pos_z_o    <= z_q[4];
        normal_x_o <= acc_q[0];
        normal_y_o <= acc_q[1];
        normal_z_o <= acc_q[2];
      end
      default: ;
    endcase
  end

  a_root_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == hgvn_pkg::OP_ACC) |-> (root != 32'd0))
    else $error("zero root at accumulate");

  a_norm_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == hgvn_pkg::OP_NORM) |=> ((mag_q[0] | mag_q[1] | mag_q[2]) != '0))
    else $error("normalized vector vanished");

  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == hgvn_pkg::OP_ACC) |->
    (dq_q[0] <= 17'd65536 && dq_q[1] <= 17'd65536 && dq_q[2] <= 17'd65536))
    else $error("unit component above one");

endmodule

>>> hw/rtl/heightmap_grid_vertex_normals.sv
// channel  | handshake                    | payload
// input    | in_valid_i / in_ready_o      | operation_i, row_i, column_i, height_sample_i
// output   | out_valid_o / out_ready_i    | pos_x_o, pos_y_o, pos_z_o, normal_x_o/y_o/z_o
// config   | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// a write is stored while idle; a read checks the range, computes the position,
// fetches the 3x3 window, and per triangle inside the grid sets up, normalizes,
// squares, roots (bit-serial, 32 steps), divides (17-step lanes), accumulates
// an out-of-range read returns to idle from the range check with no result
// reset clears control and configuration; datapath and height store are not cleared
// a result waits in the output register while the next transaction is taken
module heightmap_grid_vertex_normals #(
  parameter int MAX_WIDTH  = hgvn_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = hgvn_pkg::DEF_MAX_HEIGHT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [8:0]         row_i,
  input  logic [8:0]         column_i,
  input  logic [7:0]         height_sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [16:0]        pos_x_o,
  output logic [16:0]        pos_y_o,
  output logic [23:0]        pos_z_o,
  output logic signed [19:0] normal_x_o,
  output logic signed [19:0] normal_y_o,
  output logic signed [19:0] normal_z_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [8:0]        grid_width_q, grid_height_q;
  logic [15:0]       height_scale_q;
  logic              cfg_wr;
  hgvn_pkg::cmd_t    cmd;
  hgvn_pkg::status_t status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q   <= 9'd256;
      grid_height_q  <= 9'd256;
      height_scale_q <= 16'd256;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        hgvn_pkg::REG_GRID_WIDTH:   grid_width_q   <= pwdata[8:0];
        hgvn_pkg::REG_GRID_HEIGHT:  grid_height_q  <= pwdata[8:0];
        hgvn_pkg::REG_HEIGHT_SCALE: height_scale_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      hgvn_pkg::REG_GRID_WIDTH:   prdata = {23'd0, grid_width_q};
      hgvn_pkg::REG_GRID_HEIGHT:  prdata = {23'd0, grid_height_q};
      hgvn_pkg::REG_HEIGHT_SCALE: prdata = {16'd0, height_scale_q};
      default:                    prdata = 32'd0;
    endcase
  end

  hgvn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_oper_i   (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hgvn_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .row_i           (row_i),
    .column_i        (column_i),
    .height_sample_i (height_sample_i),
    .grid_width_i    (grid_width_q),
    .grid_height_i   (grid_height_q),
    .height_scale_i  (height_scale_q),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o),
    .pos_z_o         (pos_z_o),
    .normal_x_o      (normal_x_o),
    .normal_y_o      (normal_y_o),
    .normal_z_o      (normal_z_o)
  );

endmodule
